// ----- sv/servo_reply_line_parser_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Servo reply line parser assertion macros
// Shared property forms for the checker of the reply line parser.
// ----------------------------------------------------------------------------
`ifndef SERVO_REPLY_LINE_PARSER_UNIT_MACROS_SVH
`define SERVO_REPLY_LINE_PARSER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SRLP_ASSERT_NOW(label, pre, con) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (con)) \
      else $error("srlp: property failed");

// next-cycle implication, sampled on clock, off during reset
`define SRLP_ASSERT_NEXT(label, pre, con) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (con)) \
      else $error("srlp: property failed");

`endif

// ----- sv/srlp_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo reply line parser package
// Widths, character codes, reply tags and the line result type.
// ----------------------------------------------------------------------------
package srlp_pkg;

   localparam int LINE_MAX    = 48;
   localparam int LEN_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int PREFIX_LEN  = 6;
   localparam int PREFIX_IW   = 3;
   localparam int NUM_PARSERS = 3;
   localparam int PARSE_BASE  = 4;
   localparam int TAG_W       = 5;
   localparam int VALUE_W     = 32;
   localparam int ACC_W       = VALUE_W + 3;

   // n / 60 = (n >> 2) / 15, the latter by reciprocal (exact below 2^29 + 1)
   localparam int DIV_IN_W    = VALUE_W - 2;
   localparam int RECIP_W     = 30;
   localparam int RECIP_SHIFT = 33;
   localparam int PROD_W      = DIV_IN_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_15 = 30'd572662307;

   localparam logic [VALUE_W-1:0] MAG_CAP   = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] CHAR_1     = 8'h31;
   localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_C     = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_D     = 8'h44;
   localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CHAR_F     = 8'h46;
   localparam logic [BYTE_W-1:0] CHAR_G     = 8'h47;
   localparam logic [BYTE_W-1:0] CHAR_H     = 8'h48;
   localparam logic [BYTE_W-1:0] CHAR_L     = 8'h4C;
   localparam logic [BYTE_W-1:0] CHAR_M     = 8'h4D;
   localparam logic [BYTE_W-1:0] CHAR_Q     = 8'h51;
   localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;
   localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
   localparam logic [BYTE_W-1:0] CHAR_V     = 8'h56;

   localparam logic [TAG_W-1:0] TAG_POSITION  = 5'd0;
   localparam logic [TAG_W-1:0] TAG_SPEED     = 5'd1;
   localparam logic [TAG_W-1:0] TAG_CURRENT   = 5'd2;
   localparam logic [TAG_W-1:0] TAG_VOLTAGE   = 5'd3;
   localparam logic [TAG_W-1:0] TAG_TEMP      = 5'd4;
   localparam logic [TAG_W-1:0] TAG_STATUS    = 5'd5;
   localparam logic [TAG_W-1:0] TAG_STIFF     = 5'd6;
   localparam logic [TAG_W-1:0] TAG_HOLD      = 5'd7;
   localparam logic [TAG_W-1:0] TAG_ACCEL     = 5'd8;
   localparam logic [TAG_W-1:0] TAG_DECEL     = 5'd9;
   localparam logic [TAG_W-1:0] TAG_MAX_SPEED = 5'd10;
   localparam logic [TAG_W-1:0] TAG_LED       = 5'd11;
   localparam logic [TAG_W-1:0] TAG_GYRE      = 5'd12;
   localparam logic [TAG_W-1:0] TAG_RANGE     = 5'd13;
   localparam logic [TAG_W-1:0] TAG_MODEL     = 5'd14;
   localparam logic [TAG_W-1:0] TAG_FIRMWARE  = 5'd15;
   localparam logic [TAG_W-1:0] TAG_UNKNOWN   = 5'd16;

   typedef struct packed {
      logic [TAG_W-1:0]          tag;
      logic signed [VALUE_W-1:0] value;
      logic                      saturated;
   } line_result_type;

endpackage

// ----- sv/srlp_line_unit.sv -----
// ----------------------------------------------------------------------------
// Servo reply line parser: line unit
// Stores the line prefix, runs three number parsers and decodes the tag at
// carriage return into a registered line result.
// ----------------------------------------------------------------------------
module srlp_line_unit import srlp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   output logic                  req_stall,
   input  logic                  res_take,
   output logic                  res_valid,
   output line_result_type       res
);

   typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_DIGITS, PH_STOP} phase_type;
   typedef enum logic [1:0] {SRC_NONE, SRC_AT4, SRC_AT5, SRC_AT6} src_type;

   typedef struct packed {
      logic [VALUE_W-1:0] accum;
      phase_type          phase;
      logic               negative;
      logic               clamped;
   } parser_type;

   localparam parser_type PARSER_CLEAR = '{accum: '0, phase: PH_SKIP,
                                           negative: 1'b0, clamped: 1'b0};

   function automatic parser_type add_digit(parser_type p, logic [BYTE_W-1:0] c);
      parser_type q;
      logic [ACC_W-1:0] wide;
      q    = p;
      wide = ({3'b000, p.accum} << 3) + ({3'b000, p.accum} << 1)
             + {{(ACC_W-4){1'b0}}, c[3:0]};
      if (!p.clamped) begin
         if (wide > {3'b000, MAG_CAP}) begin
            q.accum   = MAG_CAP;
            q.clamped = 1'b1;
         end else begin
            q.accum = wide[VALUE_W-1:0];
         end
      end
      return q;
   endfunction

   function automatic parser_type feed(parser_type p, logic [BYTE_W-1:0] c);
      parser_type q;
      logic digit;
      q     = p;
      digit = (c >= CHAR_0) && (c <= CHAR_9);
      case (p.phase) inside
         PH_SKIP: begin
            if ((c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_FF))) begin
               q = p;
            end else if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
               q.negative = (c == CHAR_MINUS);
               q.phase    = PH_SIGN;
            end else if (digit) begin
               q       = add_digit(p, c);
               q.phase = PH_DIGITS;
            end else begin
               q.phase = PH_STOP;
            end
         end
         PH_SIGN, PH_DIGITS: begin
            if (digit) begin
               q       = add_digit(p, c);
               q.phase = PH_DIGITS;
            end else begin
               q.phase = PH_STOP;
            end
         end
         default: q = p;
      endcase
      return q;
   endfunction

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] prefix_ff [PREFIX_LEN];
   logic              prefix_we;
   parser_type        parser_ff [NUM_PARSERS];
   parser_type        parser_in [NUM_PARSERS];
   logic              res_valid_ff, res_valid_in;
   line_result_type   res_ff, res_in;

   logic              accept, is_cr, room;
   logic [BYTE_W-1:0] ch [PREFIX_LEN];
   logic              base;
   src_type           src;
   parser_type        sel;

   assign req_stall = res_valid_ff && !res_take;
   assign accept    = req_valid && !req_stall;
   assign is_cr     = (req_rx_byte == CHAR_CR);
   assign room      = (len_ff < LEN_W'(LINE_MAX - 1));
   assign prefix_we = accept && !is_cr && room && (len_ff < LEN_W'(PREFIX_LEN));

   // bytes beyond the stored length read as NUL
   always_comb begin
      for (int i = 0; i < PREFIX_LEN; i++) begin
         ch[i] = (LEN_W'(i) < len_ff) ? prefix_ff[i] : '0;
      end
   end

   assign base = (ch[0] == CHAR_STAR) && (ch[1] == CHAR_1) && (ch[2] == CHAR_Q);

   // longer tags ahead of shorter ones sharing a prefix
   always_comb begin
      res_in.tag = TAG_UNKNOWN;
      src        = SRC_NONE;
      if (base && ch[3] == CHAR_D) begin
         res_in.tag = TAG_POSITION;   src = SRC_AT4;
      end else if (base && ch[3] == CHAR_S && ch[4] == CHAR_D) begin
         res_in.tag = TAG_MAX_SPEED;  src = SRC_AT5;
      end else if (base && ch[3] == CHAR_S) begin
         res_in.tag = TAG_SPEED;      src = SRC_AT4;
      end else if (base && ch[3] == CHAR_C) begin
         res_in.tag = TAG_CURRENT;    src = SRC_AT4;
      end else if (base && ch[3] == CHAR_V) begin
         res_in.tag = TAG_VOLTAGE;    src = SRC_AT4;
      end else if (base && ch[3] == CHAR_T) begin
         res_in.tag = TAG_TEMP;       src = SRC_AT4;
      end else if (base && ch[3] >= CHAR_0 && ch[3] <= CHAR_9) begin
         res_in.tag = TAG_STATUS;
      end else if (base && ch[3] == CHAR_A && ch[4] == CHAR_S) begin
         res_in.tag = TAG_STIFF;      src = SRC_AT5;
      end else if (base && ch[3] == CHAR_A && ch[4] == CHAR_H) begin
         res_in.tag = TAG_HOLD;       src = SRC_AT5;
      end else if (base && ch[3] == CHAR_A && ch[4] == CHAR_A) begin
         res_in.tag = TAG_ACCEL;      src = SRC_AT5;
      end else if (base && ch[3] == CHAR_A && ch[4] == CHAR_D) begin
         res_in.tag = TAG_DECEL;      src = SRC_AT5;
      end else if (base && ch[3] == CHAR_L && ch[4] == CHAR_E && ch[5] == CHAR_D) begin
         res_in.tag = TAG_LED;        src = SRC_AT6;
      end else if (base && ch[3] == CHAR_G) begin
         res_in.tag = TAG_GYRE;       src = SRC_AT4;
      end else if (base && ch[3] == CHAR_A && ch[4] == CHAR_R) begin
         res_in.tag = TAG_RANGE;      src = SRC_AT5;
      end else if (base && ch[3] == CHAR_M && ch[4] == CHAR_S) begin
         res_in.tag = TAG_MODEL;
      end else if (base && ch[3] == CHAR_F) begin
         res_in.tag = TAG_FIRMWARE;
      end

      unique case (src)
         SRC_AT4: sel = parser_ff[0];
         SRC_AT5: sel = parser_ff[1];
         SRC_AT6: sel = parser_ff[2];
         default: sel = PARSER_CLEAR;
      endcase
      res_in.value     = '0;
      res_in.saturated = 1'b0;
      if (res_in.tag == TAG_STATUS) begin
         res_in.value = {{(VALUE_W-4){1'b0}}, ch[3][3:0]};
      end else if (src != SRC_NONE) begin
         if (sel.negative) begin
            res_in.value     = -sel.accum;
            res_in.saturated = sel.clamped;
         end else if (sel.accum[VALUE_W-1]) begin
            res_in.value     = VALUE_MAX;
            res_in.saturated = 1'b1;
         end else begin
            res_in.value = sel.accum;
         end
      end
   end

   always_comb begin
      len_in = len_ff;
      for (int k = 0; k < NUM_PARSERS; k++) begin
         parser_in[k] = parser_ff[k];
      end
      if (accept && is_cr) begin
         len_in = '0;
         for (int k = 0; k < NUM_PARSERS; k++) begin
            parser_in[k] = PARSER_CLEAR;
         end
      end else if (accept && room) begin
         len_in = len_ff + LEN_W'(1);
         for (int k = 0; k < NUM_PARSERS; k++) begin
            if (len_ff >= LEN_W'(PARSE_BASE + k)) begin
               parser_in[k] = feed(parser_ff[k], req_rx_byte);
            end
         end
      end
      if (accept && is_cr) begin
         res_valid_in = 1'b1;
      end else if (res_take) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         res_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_PARSERS; k++) begin
            parser_ff[k] <= PARSER_CLEAR;
         end
      end else begin
         len_ff       <= len_in;
         res_valid_ff <= res_valid_in;
         for (int k = 0; k < NUM_PARSERS; k++) begin
            parser_ff[k] <= parser_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prefix_we) begin
         prefix_ff[len_ff[PREFIX_IW-1:0]] <= req_rx_byte;
      end
      if (accept && is_cr) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

// ----- sv/srlp_scale_unit.sv -----
// ----------------------------------------------------------------------------
// Servo reply line parser: scale unit
// Divides speed replies by 60 and holds the result item for the receiver.
// ----------------------------------------------------------------------------
module srlp_scale_unit import srlp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      res_valid,
   input  line_result_type           res,
   output logic                      res_take,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [TAG_W-1:0]          rsp_reply_tag,
   output logic signed [VALUE_W-1:0] rsp_reply_value,
   output logic                      rsp_value_saturated
);

   logic                      rsp_valid_ff, rsp_valid_in;
   line_result_type           out_ff, out_in;

   logic                      neg;
   logic [VALUE_W-1:0]        mag;
   logic [PROD_W-1:0]         prod;
   logic [VALUE_W-1:0]        quot;

   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   // truncation toward zero: divide the magnitude, restore the sign
   assign neg  = res.value[VALUE_W-1];
   assign mag  = neg ? (~res.value + VALUE_W'(1)) : res.value;
   assign prod = {{RECIP_W{1'b0}}, mag[VALUE_W-1:2]} * {{DIV_IN_W{1'b0}}, RECIP_15};
   assign quot = VALUE_W'(prod >> RECIP_SHIFT);

   always_comb begin
      out_in = res;
      if (res.tag == TAG_SPEED) begin
         out_in.value = neg ? -quot : quot;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reply_tag       = out_ff.tag;
   assign rsp_reply_value     = out_ff.value;
   assign rsp_value_saturated = out_ff.saturated;

endmodule

// ----- sv/servo_reply_line_parser_unit.sv -----
// ----------------------------------------------------------------------------
// Servo reply line parser
// Byte-wide reply stream in, one decoded reply item out per line.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one received byte per item (req_rx_byte). Any byte but a
//   carriage return updates the line state and gives no result; a carriage
//   return closes the line and gives exactly one rsp_ item (tag, value,
//   saturation flag), after which the line state starts afresh.
//   Bytes after the 47th of a line are dropped.
//   Throughput: one byte per cycle while req_stall is low; set by the
//   line state update (prefix store plus three shift-add number parsers).
//   After the carriage return is accepted, the result item passes the line
//   result register, then the divide by 60 stage into the output register,
//   and then shows on rsp_valid.
//   A stalled result holds on rsp_; bytes keep being taken while one result
//   waits there. req_stall rises only when both result registers are full
//   and rsp_stall is high.
//   Reset (synchronous, active high) empties both result registers and
//   starts a fresh line; no clearing pass is needed.
// ----------------------------------------------------------------------------
module servo_reply_line_parser_unit import srlp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [BYTE_W-1:0]         req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [TAG_W-1:0]          rsp_reply_tag,
   output logic signed [VALUE_W-1:0] rsp_reply_value,
   output logic                      rsp_value_saturated
);

   logic            res_valid;
   logic            res_take;
   line_result_type res;

   srlp_line_unit u_line (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .res_take    (res_take),
      .res_valid   (res_valid),
      .res         (res)
   );

   srlp_scale_unit u_scale (
      .clock               (clock),
      .reset               (reset),
      .res_valid           (res_valid),
      .res                 (res),
      .res_take            (res_take),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_reply_tag       (rsp_reply_tag),
      .rsp_reply_value     (rsp_reply_value),
      .rsp_value_saturated (rsp_value_saturated)
   );

endmodule

// ----- sv/srlp_checker.sv -----
// ----------------------------------------------------------------------------
// Servo reply line parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "servo_reply_line_parser_unit_macros.svh"

module srlp_checker import srlp_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [BYTE_W-1:0]         req_rx_byte,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [TAG_W-1:0]          rsp_reply_tag,
   input logic signed [VALUE_W-1:0] rsp_reply_value,
   input logic                      rsp_value_saturated
);

   `SRLP_ASSERT_NEXT(a_rsp_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_reply_tag) && $stable(rsp_reply_value) && $stable(rsp_value_saturated))

   `SRLP_ASSERT_NOW(a_rsp_after_cr, $rose(rsp_valid), $past(req_valid && !req_stall && (req_rx_byte == CHAR_CR), 2))

   `SRLP_ASSERT_NOW(a_status_digit, rsp_valid && (rsp_reply_tag == TAG_STATUS), !rsp_value_saturated && (rsp_reply_value >= 0) && (rsp_reply_value <= 9))

   `SRLP_ASSERT_NOW(a_sat_clamped, rsp_valid && rsp_value_saturated, (rsp_reply_value == VALUE_MAX) || (rsp_reply_value == VALUE_MIN) || (rsp_reply_tag == TAG_SPEED))

endmodule

bind servo_reply_line_parser_unit srlp_checker u_checker (.*);

// ----- sim/servo_reply_line_parser_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo reply line parser testbench
// Streams reply lines into the parser byte by byte: directed lines for every
// tag, the value limits and the odd line shapes, then random well-formed
// lines, noise and over-long lines, unthrottled, then bursty with random
// result stalls. A line-level predictor queues the expected reply item for
// each carriage return and a checker compares every result item against it.
// ----------------------------------------------------------------------------
module servo_reply_line_parser_unit_tb;
   import srlp_pkg::*;

   localparam int CLOCK_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;

   typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_DIGITS, PH_STOP} num_phase_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic [BYTE_W-1:0]         req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic [TAG_W-1:0]          rsp_reply_tag;
   logic signed [VALUE_W-1:0] rsp_reply_value;
   logic                      rsp_value_saturated;

   servo_reply_line_parser_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_reply_tag       (rsp_reply_tag),
      .rsp_reply_value     (rsp_reply_value),
      .rsp_value_saturated (rsp_value_saturated)
   );

   // line state of the predictor
   int unsigned       line_len;
   logic [BYTE_W-1:0] prefix [PREFIX_LEN];
   logic [35:0]       num_mag [NUM_PARSERS];
   num_phase_type     num_ph [NUM_PARSERS];
   bit                num_neg [NUM_PARSERS];
   bit                num_clamp [NUM_PARSERS];

   line_result_type pending_replies [$];

   int unsigned cycle_count = 0;
   int unsigned fail_count  = 0;
   int unsigned bytes_sent  = 0;
   int          burst_left  = 0;
   int          gap_max     = 0;
   int          stall_pct   = 0;
   int          stall_max   = 1;
   int          stall_left  = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CLOCK_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic void clear_line();
      line_len = 0;
      for (int i = 0; i < PREFIX_LEN; i++) prefix[i] = '0;
      for (int k = 0; k < NUM_PARSERS; k++) begin
         num_mag[k]   = '0;
         num_ph[k]    = PH_SKIP;
         num_neg[k]   = 1'b0;
         num_clamp[k] = 1'b0;
      end
   endfunction

   function automatic logic [BYTE_W-1:0] line_char(int unsigned i);
      if (i < PREFIX_LEN && i < line_len) return prefix[i];
      return 8'h00;
   endfunction

   function automatic bit tag_is(string t);
      for (int i = 0; i < t.len(); i++)
         if (line_char(i) != t[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit is_digit(logic [BYTE_W-1:0] c);
      return c >= CHAR_0 && c <= CHAR_9;
   endfunction

   function automatic void add_digit(int k, logic [BYTE_W-1:0] c);
      if (num_clamp[k]) return;
      num_mag[k] = num_mag[k] * 10 + (c - CHAR_0);
      if (num_mag[k] > MAG_CAP) begin
         num_mag[k]   = MAG_CAP;
         num_clamp[k] = 1'b1;
      end
   endfunction

   function automatic void feed_number(int k, logic [BYTE_W-1:0] c);
      case (num_ph[k])
         PH_SKIP: begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_FF)) begin
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               num_neg[k] = (c == CHAR_MINUS);
               num_ph[k]  = PH_SIGN;
            end else if (is_digit(c)) begin
               add_digit(k, c);
               num_ph[k] = PH_DIGITS;
            end else begin
               num_ph[k] = PH_STOP;
            end
         end
         PH_SIGN, PH_DIGITS: begin
            if (is_digit(c)) begin
               add_digit(k, c);
               num_ph[k] = PH_DIGITS;
            end else begin
               num_ph[k] = PH_STOP;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic line_result_type close_line();
      line_result_type r;
      int     src = -1;
      longint v   = 0;
      bit     sat = 1'b0;
      r.tag = TAG_UNKNOWN;
      if (tag_is("*1QD"))         begin r.tag = TAG_POSITION;  src = 0; end
      else if (tag_is("*1QSD"))   begin r.tag = TAG_MAX_SPEED; src = 1; end
      else if (tag_is("*1QS"))    begin r.tag = TAG_SPEED;     src = 0; end
      else if (tag_is("*1QC"))    begin r.tag = TAG_CURRENT;   src = 0; end
      else if (tag_is("*1QV"))    begin r.tag = TAG_VOLTAGE;   src = 0; end
      else if (tag_is("*1QT"))    begin r.tag = TAG_TEMP;      src = 0; end
      else if (tag_is("*1Q") && is_digit(line_char(3))) begin
         r.tag = TAG_STATUS;
         v     = line_char(3) - CHAR_0;
      end
      else if (tag_is("*1QAS"))   begin r.tag = TAG_STIFF;     src = 1; end
      else if (tag_is("*1QAH"))   begin r.tag = TAG_HOLD;      src = 1; end
      else if (tag_is("*1QAA"))   begin r.tag = TAG_ACCEL;     src = 1; end
      else if (tag_is("*1QAD"))   begin r.tag = TAG_DECEL;     src = 1; end
      else if (tag_is("*1QLED"))  begin r.tag = TAG_LED;       src = 2; end
      else if (tag_is("*1QG"))    begin r.tag = TAG_GYRE;      src = 0; end
      else if (tag_is("*1QAR"))   begin r.tag = TAG_RANGE;     src = 1; end
      else if (tag_is("*1QMS"))   r.tag = TAG_MODEL;
      else if (tag_is("*1QF"))    r.tag = TAG_FIRMWARE;

      if (src >= 0) begin
         v = num_mag[src];
         if (num_neg[src]) begin
            sat = num_clamp[src];
            v   = -v;
         end else if (num_clamp[src] || num_mag[src] > VALUE_MAX) begin
            sat = 1'b1;
            v   = VALUE_MAX;
         end
         if (r.tag == TAG_SPEED) v = v / 60;
      end
      r.value     = v[VALUE_W-1:0];
      r.saturated = sat;
      return r;
   endfunction

   function automatic void absorb_byte(logic [BYTE_W-1:0] c);
      if (c == CHAR_CR) begin
         pending_replies.push_back(close_line());
         clear_line();
      end else if (line_len < LINE_MAX - 1) begin
         if (line_len < PREFIX_LEN) prefix[line_len] = c;
         for (int k = 0; k < NUM_PARSERS; k++)
            if (line_len >= PARSE_BASE + k) feed_number(k, c);
         line_len++;
      end
   endfunction

   // ---------------- result side ----------------

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct) begin
         stall_left = $urandom_range(stall_max - 1, 0);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            note_failure($sformatf("unexpected reply: tag %0d value %0d sat %0b",
                                   rsp_reply_tag, rsp_reply_value, rsp_value_saturated));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_reply_tag !== want.tag || rsp_reply_value !== want.value ||
                rsp_value_saturated !== want.saturated)
               note_failure($sformatf(
                  "reply mismatch: expected tag %0d value %0d sat %0b, got tag %0d value %0d sat %0b",
                  want.tag, want.value, want.saturated,
                  rsp_reply_tag, rsp_reply_value, rsp_value_saturated));
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      absorb_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit end_line);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      if (end_line) send_byte(CHAR_CR);
   endtask

   function automatic string pick_tag(int idx);
      case (idx)
         0:  return "*1QD";
         1:  return "*1QS";
         2:  return "*1QC";
         3:  return "*1QV";
         4:  return "*1QT";
         5:  return "*1QAS";
         6:  return "*1QAH";
         7:  return "*1QAA";
         8:  return "*1QAD";
         9:  return "*1QSD";
         10: return "*1QLED";
         11: return "*1QG";
         12: return "*1QAR";
         13: return "*1QMS";
         14: return "*1QF";
         15: return "*1QA";
         16: return "*1QL";
         default: return "*1Q";
      endcase
   endfunction

   function automatic void push_text(ref logic [BYTE_W-1:0] q [$], input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic logic [BYTE_W-1:0] random_digit();
      return BYTE_W'(CHAR_0 + $urandom_range(9, 0));
   endfunction

   function automatic logic [BYTE_W-1:0] random_byte();
      return BYTE_W'($urandom_range(255, 0));
   endfunction

   function automatic void push_number(ref logic [BYTE_W-1:0] q [$]);
      longint unsigned n;
      case ($urandom_range(5, 0))
         0, 1: push_text(q, $sformatf("%0d", $urandom_range(9999, 0)));
         2: begin
            n = 64'($urandom);
            push_text(q, $sformatf("%0d", n));
         end
         3: begin
            n = 64'd2147483640 + 64'($urandom_range(16, 0));
            push_text(q, $sformatf("%0d", n));
         end
         4: repeat ($urandom_range(14, 11)) q.push_back(random_digit());
         default: ;
      endcase
   endfunction

   task automatic send_random_line();
      logic [BYTE_W-1:0] q [$];
      int kind = $urandom_range(99, 0);
      int tag_idx;
      int target;
      if (kind < 75) begin
         tag_idx = $urandom_range(17, 0);
         push_text(q, pick_tag(tag_idx));
         if (tag_idx == 17 && $urandom_range(3, 0) != 0) q.push_back(random_digit());
         if ($urandom_range(3, 0) == 0)
            repeat ($urandom_range(3, 1))
               q.push_back(($urandom_range(1, 0) == 0) ? CHAR_SPACE
                           : BYTE_W'(CHAR_TAB + $urandom_range(3, 0)));
         case ($urandom_range(3, 0))
            0: q.push_back(CHAR_MINUS);
            1: q.push_back(CHAR_PLUS);
            default: ;
         endcase
         if ($urandom_range(7, 0) == 0) repeat ($urandom_range(3, 1)) q.push_back(CHAR_0);
         push_number(q);
         if ($urandom_range(5, 0) == 0) q.push_back(random_byte());
         if ($urandom_range(9, 0) == 0 && q.size() > 0)
            q[$urandom_range(q.size() - 1, 0)] = random_byte();
      end else if (kind < 92) begin
         repeat ($urandom_range(12, 0)) q.push_back(random_byte());
      end else begin
         push_text(q, pick_tag($urandom_range(17, 0)));
         target = $urandom_range(62, 44);
         while (q.size() < target)
            q.push_back(($urandom_range(7, 0) == 0) ? random_byte() : random_digit());
      end
      foreach (q[i]) send_byte(q[i]);
      send_byte(CHAR_CR);
   endtask

   task automatic test_every_tag();
      send_text("*1QD-1234", 1);
      send_text("*1QS-600", 1);
      send_text("*1QC12", 1);
      send_text("*1QV11200", 1);
      send_text("*1QT35", 1);
      send_text("*1Q6", 1);
      send_text("*1QAS-2", 1);
      send_text("*1QAH3", 1);
      send_text("*1QAA100", 1);
      send_text("*1QAD50", 1);
      send_text("*1QSD1800", 1);
      send_text("*1QLED4", 1);
      send_text("*1QG-1", 1);
      send_text("*1QAR1800", 1);
      send_text("*1QMS27", 1);
      send_text("*1QF368", 1);
      send_text("*2QD5", 1);
   endtask

   task automatic test_value_limits();
      send_text("*1QD2147483647", 1);
      send_text("*1QD-2147483648", 1);
      send_text("*1QD2147483648", 1);
      send_text("*1QAS-99999999999", 1);
      send_text("*1QS-2147483648", 1);
      send_byte(CHAR_CR);
      send_text("*1QS", 0);
      send_byte(CHAR_TAB);
      send_byte(CHAR_FF);
      send_text(" +59", 1);
   endtask

   task automatic test_line_edges();
      send_text("*1Q", 1);
      send_text("*1QD", 0);
      send_byte(8'h00);
      send_text("12", 1);
      send_text("*1QT", 0);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(CHAR_CR);
      send_text("*1QD  abc", 1);
      // over-long line: digits beyond the stored length are dropped
      send_text("*1QC", 0);
      repeat (55) send_byte(CHAR_1);
      send_byte(CHAR_CR);
   endtask

   task automatic test_random_lines(input int unsigned n_bytes);
      int unsigned stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) send_random_line();
   endtask

   initial begin
      clear_line();
      gap_max   = 2;
      stall_pct = 20;
      stall_max = 3;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_every_tag();
      test_value_limits();
      test_line_edges();

      gap_max   = 0;
      stall_pct = 0;
      test_random_lines(540);

      gap_max   = 4;
      stall_pct = 30;
      stall_max = 4;
      test_random_lines(540);

      gap_max   = 12;
      stall_pct = 60;
      stall_max = 12;
      test_random_lines(540);

      @(negedge clock) req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/srlp_pkg.sv
sv/srlp_line_unit.sv
sv/srlp_scale_unit.sv
sv/servo_reply_line_parser_unit.sv
sv/srlp_checker.sv
sim/servo_reply_line_parser_unit_tb.sv
